@@ hw/rtl/kdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// kdlp_pkg: shared types and constants of the key debounce / long press block
// Event codes, register indexes and the event group word between front and back.
// ----------------------------------------------------------------------------
package kdlp_pkg;

  localparam int unsigned MaxKeys  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CntW     = 16;
  localparam int unsigned ChgW     = 17;

  localparam logic [CntW-1:0] DebounceReset = 16'd2;
  localparam logic [CntW-1:0] MaxHoldReset  = 16'hFFFF;

  typedef enum logic [1:0] {
    EvPress   = 2'd0,
    EvRelease = 2'd1,
    EvLong    = 2'd2
  } kdlp_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegDebounce  = 3'd0,
    RegMaxHold   = 3'd1,
    RegLongKey0  = 3'd2,
    RegLongKey1  = 3'd3,
    RegLongKey2  = 3'd4,
    RegLongKey3  = 3'd5
  } kdlp_reg_e;

  // events caused by one scan tick, one lane per key
  typedef struct packed {
    logic        [MaxKeys-1:0] fire;
    kdlp_event_e [MaxKeys-1:0] kind;
  } kdlp_group_t;

endpackage

@@ hw/rtl/kdlp_front.sv @@
// ----------------------------------------------------------------------------
// kdlp_front: configuration registers and per-key debounce state
// Takes one tick per cycle unless the queue is full; builds its event group.
// ----------------------------------------------------------------------------
module kdlp_front import kdlp_pkg::*; #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [MaxKeys-1:0]  raw_levels_i,
  output logic                in_stall_o,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                q_full_i,
  output logic                push_o,
  output kdlp_group_t         grp_o
);

  logic [CntW-1:0] deb_q, max_q;
  logic [CntW-1:0] lim_q [NUM_KEYS];

  logic            pressed_q [NUM_KEYS];
  logic            pressed_d [NUM_KEYS];
  logic [ChgW-1:0] chg_q     [NUM_KEYS];
  logic [ChgW-1:0] chg_d     [NUM_KEYS];
  logic [CntW-1:0] hold_q    [NUM_KEYS];
  logic [CntW-1:0] hold_d    [NUM_KEYS];
  logic [ChgW-1:0] chg_inc   [NUM_KEYS];
  logic [CntW-1:0] hold_nxt  [NUM_KEYS];

  logic accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign push_o     = accept & (|grp_o.fire);

  // config write decode; indexes past the list fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= DebounceReset;
      max_q <= MaxHoldReset;
      for (int k = 0; k < NUM_KEYS; k++) lim_q[k] <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegDebounce) deb_q <= cfg_data_i;
      if (cfg_index_i == RegMaxHold)  max_q <= cfg_data_i;
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (cfg_index_i == CfgIdxW'(RegLongKey0 + k)) lim_q[k] <= cfg_data_i;
      end
    end
  end

  always_comb begin
    grp_o = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      chg_inc[k]   = chg_q[k] + ChgW'(1);
      hold_nxt[k]  = (hold_q[k] < max_q) ? hold_q[k] + CntW'(1) : hold_q[k];
      pressed_d[k] = pressed_q[k];
      chg_d[k]     = chg_q[k];
      hold_d[k]    = hold_q[k];
      if (pressed_q[k]) begin
        if (raw_levels_i[k]) begin
          chg_d[k] = '0;
          if (lim_q[k] != '0) begin
            hold_d[k] = hold_nxt[k];
            if (hold_nxt[k] == lim_q[k]) begin
              grp_o.fire[k] = 1'b1;
              grp_o.kind[k] = EvLong;
            end
          end
        end else begin
          chg_d[k] = chg_inc[k];
          if (chg_inc[k] > {1'b0, deb_q}) begin
            pressed_d[k]  = 1'b0;
            chg_d[k]      = '0;
            grp_o.fire[k] = 1'b1;
            grp_o.kind[k] = EvRelease;
          end
        end
      end else if (raw_levels_i[k]) begin
        hold_d[k] = '0;
        chg_d[k]  = chg_inc[k];
        if (chg_inc[k] > {1'b0, deb_q}) begin
          pressed_d[k]  = 1'b1;
          chg_d[k]      = '0;
          grp_o.fire[k] = 1'b1;
          grp_o.kind[k] = EvPress;
        end
      end else begin
        chg_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        pressed_q[k] <= 1'b0;
        chg_q[k]     <= '0;
        hold_q[k]    <= '0;
      end
    end else if (accept) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        pressed_q[k] <= pressed_d[k];
        chg_q[k]     <= chg_d[k];
        hold_q[k]    <= hold_d[k];
      end
    end
  end

endmodule

@@ hw/rtl/kdlp_queue.sv @@
// ----------------------------------------------------------------------------
// kdlp_queue: two-entry queue of event groups
// Decouples the tick front end from the event serializer.
// ----------------------------------------------------------------------------
module kdlp_queue import kdlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  kdlp_group_t wdata_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output kdlp_group_t rdata_o
);

  localparam int unsigned Depth = 2;

  kdlp_group_t mem_q [Depth];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

@@ hw/rtl/kdlp_back.sv @@
// ----------------------------------------------------------------------------
// kdlp_back: event serializer
// Walks the head group lowest key first, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module kdlp_back import kdlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  kdlp_group_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  key_index_o,
  output kdlp_event_e event_kind_o,
  output logic        last_event_o
);

  logic [MaxKeys-1:0] done_q, done_d;
  logic [MaxKeys-1:0] pending, lowest, rest;
  logic [1:0]         sel;
  logic               load, out_valid_q, out_valid_d;
  logic [1:0]         key_q;
  kdlp_event_e        kind_q;
  logic               last_q;

  assign pending = head_i.fire & ~done_q;
  assign lowest  = pending & (~pending + MaxKeys'(1));
  assign rest    = pending & ~lowest;

  always_comb begin
    sel = '0;
    for (int k = MaxKeys - 1; k >= 0; k--) begin
      if (pending[k]) sel = 2'(k);
    end
  end

  assign load  = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = load & (rest == '0);

  always_comb begin
    done_d = done_q;
    if (load) done_d = (rest == '0) ? '0 : (done_q | lowest);
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q  <= sel;
      kind_q <= head_i.kind[sel];
      last_q <= (rest == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_index_o  = key_q;
  assign event_kind_o = kind_q;
  assign last_event_o = last_q;

endmodule

@@ hw/rtl/key_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// key_debounce_long_press: debounced keys with press, release and long press
// Scan ticks in, event words out in ascending key order with a last marker.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+--------------------------------
//  in      | in  | in_valid_i / in_stall_o   | raw_levels_i
//  out     | out | out_valid_o / out_stall_i | key_index_o, event_kind_o,
//          |     |                           | last_event_o
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  The front end takes one tick per cycle while in_stall_o is low and updates
//  all key state in that cycle. The serializer sends one event word per cycle
//  while out_stall_i is low, so a tick that makes n events holds the back end
//  for n words. Ticks without events never reach the queue. A two-entry group
//  queue sits between the parts; in_stall_o rises only when it is full.
//  Groups are registered in the queue and words at the output. Reset (async,
//  low) releases all keys, clears counters and loads register defaults; no
//  clearing pass is needed. Config writes are always ready.
// ----------------------------------------------------------------------------
module key_debounce_long_press import kdlp_pkg::*; #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tick channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [3:0]          raw_levels_i,
  // event channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          key_index_o,
  output logic [1:0]          event_kind_o,
  output logic                last_event_o,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  kdlp_group_t grp, head;
  logic        push, q_full, head_valid, pop;
  kdlp_event_e kind;

  // registers never back-pressure
  assign cfg_ready_o = 1'b1;

  kdlp_front #(.NUM_KEYS(NUM_KEYS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .raw_levels_i (raw_levels_i),
    .in_stall_o   (in_stall_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .grp_o        (grp)
  );

  // one group per eventful tick
  kdlp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (grp),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head)
  );

  kdlp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_index_o  (key_index_o),
    .event_kind_o (kind),
    .last_event_o (last_event_o)
  );

  assign event_kind_o = kind;

endmodule

@@ hw/rtl/kdlp_checker.sv @@
// ----------------------------------------------------------------------------
// kdlp_checker: port-level checks for key_debounce_long_press
// Watches the event channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module kdlp_checker #(
  parameter int unsigned NumKeys = 4
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [1:0]          key_index_o,
  input logic [1:0]          event_kind_o,
  input logic                last_event_o
);

  logic       out_acc;
  logic       mid_q;
  logic [1:0] prev_key_q;

  assign out_acc = out_valid_o & ~out_stall_i;

  // tracks whether a tick's event run is open, and its last key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q      <= 1'b0;
      prev_key_q <= '0;
    end else if (out_acc) begin
      mid_q      <= ~last_event_o;
      prev_key_q <= key_index_o;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("event word valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_index_o)
      && $stable(event_kind_o) && $stable(last_event_o))
    else $error("stalled event word changed");

  a_kind_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_kind_o != 2'd3) && (32'(key_index_o) < NumKeys))
    else $error("event word carries a bad key or kind");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && mid_q |-> key_index_o > prev_key_q)
    else $error("events of one tick out of key order");

endmodule

bind key_debounce_long_press kdlp_checker #(.NumKeys(NUM_KEYS)) u_kdlp_checker (.*);
